// ===== rtl/ppts_pkg.sv =====
// shared constants and types for the perspective point-to-screen block
// no dependencies
`timescale 1ns / 1ps

package ppts_pkg;

   localparam int FRAC_BITS_DEF   = 16;
   localparam int COORD_WIDTH_DEF = 32;
   localparam int VIEW_BITS       = 14;
   localparam int CSR_IDX_BITS    = 3;

   localparam logic [VIEW_BITS-1:0] VIEW_WIDTH_RST  = 14'd640;
   localparam logic [VIEW_BITS-1:0] VIEW_HEIGHT_RST = 14'd480;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_X_SCALE     = 3'd0,
      REG_X_OFFSET    = 3'd1,
      REG_Y_SCALE     = 3'd2,
      REG_Y_OFFSET    = 3'd3,
      REG_VIEW_WIDTH  = 3'd4,
      REG_VIEW_HEIGHT = 3'd5
   } csr_idx_type;

   // sideband that rides along the divider chain
   typedef struct packed {
      logic neg;
      logic ovf;
   } div_side_type;

endpackage

// ===== rtl/ppts_axis_front.sv =====
// front end of one axis: products, signed sum, magnitude and viewport scaling
// three register stages; uses ppts_pkg
`timescale 1ns / 1ps

module ppts_axis_front #(
   parameter int COORD_WIDTH = ppts_pkg::COORD_WIDTH_DEF,
   parameter int NW = 2 * COORD_WIDTH + 3,
   parameter int PW = NW + ppts_pkg::VIEW_BITS + 1
) (
   input  logic                            clock,
   input  logic signed [COORD_WIDTH:0]     lin,
   input  logic signed [COORD_WIDTH-1:0]   coord,
   input  logic signed [COORD_WIDTH:0]     zc,
   input  logic signed [COORD_WIDTH-1:0]   z,
   input  logic [ppts_pkg::VIEW_BITS-1:0]  span,
   output logic [PW-1:0]                   prod,
   output logic [COORD_WIDTH:0]            divisor,
   output logic                            neg
);

   localparam int PRW = 2 * COORD_WIDTH + 2;

   // stage 1
   logic signed [PRW-1:0]                p1_ff, p1_in, p2_ff, p2_in;
   logic                                 zneg1_ff;
   logic [COORD_WIDTH-1:0]               az1_ff, az1_in;
   logic [ppts_pkg::VIEW_BITS-1:0]       span1_ff;
   // stage 2
   logic [NW-1:0]                        m2_ff, m2_in;
   logic signed [NW-1:0]                 n2;
   logic                                 neg2_ff;
   logic [COORD_WIDTH-1:0]               az2_ff;
   logic [ppts_pkg::VIEW_BITS-1:0]       span2_ff;
   // stage 3
   logic [PW-1:0]                        prod3_ff, prod3_in;
   logic [COORD_WIDTH:0]                 d3_ff;
   logic                                 neg3_ff;

   always_comb begin
      p1_in  = PRW'(lin * $signed({coord[COORD_WIDTH-1], coord}));
      p2_in  = PRW'(zc * $signed({z[COORD_WIDTH-1], z}));
      az1_in = z[COORD_WIDTH-1] ? COORD_WIDTH'(-z) : COORD_WIDTH'(z);
   end

   always_comb begin
      n2    = NW'(p1_ff) + NW'(p2_ff);
      m2_in = n2[NW-1] ? NW'(-n2) : NW'(n2);
   end

   always_comb begin
      prod3_in = PW'(m2_ff) * PW'(span2_ff) + PW'(az2_ff);
   end

   always_ff @(posedge clock) begin
      p1_ff    <= p1_in;
      p2_ff    <= p2_in;
      zneg1_ff <= z[COORD_WIDTH-1];
      az1_ff   <= az1_in;
      span1_ff <= span;

      m2_ff    <= m2_in;
      neg2_ff  <= n2[NW-1] ^ zneg1_ff;
      az2_ff   <= az1_ff;
      span2_ff <= span1_ff;

      prod3_ff <= prod3_in;
      d3_ff    <= {az2_ff, 1'b0};
      neg3_ff  <= neg2_ff;
   end

   assign prod    = prod3_ff;
   assign divisor = d3_ff;
   assign neg     = neg3_ff;

endmodule

// ===== rtl/ppts_div_step.sv =====
// one restoring divide step: one quotient bit per stage, registered
// uses ppts_pkg for the sideband struct
`timescale 1ns / 1ps

module ppts_div_step #(
   parameter int W = ppts_pkg::COORD_WIDTH_DEF + 1
) (
   input  logic                    clock,
   input  logic [W-1:0]            rem_i,
   input  logic [W-1:0]            low_i,
   input  logic [W-1:0]            quo_i,
   input  logic [W-1:0]            div_i,
   input  ppts_pkg::div_side_type  side_i,
   output logic [W-1:0]            rem_o,
   output logic [W-1:0]            low_o,
   output logic [W-1:0]            quo_o,
   output logic [W-1:0]            div_o,
   output ppts_pkg::div_side_type  side_o
);

   logic [W:0]                trial, diff;
   logic                      ge;
   logic [W-1:0]              rem_ff, rem_in, low_ff, quo_ff, div_ff;
   ppts_pkg::div_side_type    side_ff;

   always_comb begin
      trial  = {rem_i, low_i[W-1]};
      diff   = trial - {1'b0, div_i};
      ge     = (trial >= {1'b0, div_i});
      rem_in = ge ? diff[W-1:0] : trial[W-1:0];
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      low_ff  <= {low_i[W-2:0], 1'b0};
      quo_ff  <= {quo_i[W-2:0], ge};
      div_ff  <= div_i;
      side_ff <= side_i;
   end

   assign rem_o  = rem_ff;
   assign low_o  = low_ff;
   assign quo_o  = quo_ff;
   assign div_o  = div_ff;
   assign side_o = side_ff;

endmodule

// ===== rtl/ppts_axis_div.sv =====
// pipelined divide and saturation for one axis
// instantiates ppts_div_step; uses ppts_pkg
`timescale 1ns / 1ps

module ppts_axis_div #(
   parameter int COORD_WIDTH = ppts_pkg::COORD_WIDTH_DEF,
   parameter int PW = 2 * COORD_WIDTH + 3 + ppts_pkg::VIEW_BITS + 1
) (
   input  logic                    clock,
   input  logic [PW-1:0]           prod,
   input  logic [COORD_WIDTH:0]    divisor,
   input  logic                    neg,
   output logic [COORD_WIDTH-1:0]  result
);

   localparam int QB = COORD_WIDTH + 1;
   localparam int HW = PW - QB;
   localparam logic [COORD_WIDTH-1:0] MAX_POS = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic [COORD_WIDTH-1:0] MIN_NEG = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   logic [HW-1:0]             hi;
   logic                      ovf;
   logic [QB-1:0]             rem_s [QB+1];
   logic [QB-1:0]             low_s [QB+1];
   logic [QB-1:0]             quo_s [QB+1];
   logic [QB-1:0]             div_s [QB+1];
   ppts_pkg::div_side_type    side_s [QB+1];
   logic [QB-1:0]             rem0_ff, low0_ff, div0_ff;
   ppts_pkg::div_side_type    side0_ff;
   logic [QB-1:0]             q;
   logic                      pos_over, neg_over;
   logic [COORD_WIDTH-1:0]    res_ff, res_in;

   // quotient fits QB bits exactly when the upper part is below the divisor
   always_comb begin
      hi  = prod[PW-1:QB];
      ovf = (hi >= HW'(divisor));
   end

   always_ff @(posedge clock) begin
      rem0_ff      <= ovf ? '0 : hi[QB-1:0];
      low0_ff      <= prod[QB-1:0];
      div0_ff      <= divisor;
      side0_ff.neg <= neg;
      side0_ff.ovf <= ovf;
   end

   assign rem_s[0]  = rem0_ff;
   assign low_s[0]  = low0_ff;
   assign quo_s[0]  = '0;
   assign div_s[0]  = div0_ff;
   assign side_s[0] = side0_ff;

   for (genvar i = 0; i < QB; i++) begin : g_step
      ppts_div_step #(.W(QB)) u_step (
         .clock  (clock),
         .rem_i  (rem_s[i]),
         .low_i  (low_s[i]),
         .quo_i  (quo_s[i]),
         .div_i  (div_s[i]),
         .side_i (side_s[i]),
         .rem_o  (rem_s[i+1]),
         .low_o  (low_s[i+1]),
         .quo_o  (quo_s[i+1]),
         .div_o  (div_s[i+1]),
         .side_o (side_s[i+1])
      );
   end

   always_comb begin
      q        = quo_s[QB];
      pos_over = |q[QB-1:COORD_WIDTH-1];
      neg_over = q[COORD_WIDTH] | (q[COORD_WIDTH-1] & (|q[COORD_WIDTH-2:0]));
      if (side_s[QB].neg) begin
         res_in = (side_s[QB].ovf || neg_over) ? MIN_NEG : COORD_WIDTH'(-q);
      end else begin
         res_in = (side_s[QB].ovf || pos_over) ? MAX_POS : q[COORD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign result = res_ff;

endmodule

// ===== rtl/perspective_point_to_screen.sv =====
// top level of the perspective point-to-screen block: registers, two axis paths
// uses ppts_pkg, ppts_axis_front and ppts_axis_div
`timescale 1ns / 1ps

// Projects a camera-space point (x, y, z), signed fixed point, to screen
// coordinates in the same format through the projection coefficients and the
// viewport size held in the csr registers.
// Input: a word is taken at each clock edge with start high and busy low.
// busy is always low, so a new point may enter on every cycle.
// Output: rsp_valid marks each result word for one cycle; the receiver cannot
// stall, and none is needed since every result is shown exactly once.
// The pipeline holds three stages of products and scaling, one overflow check,
// one restoring divide step per quotient bit and one saturation stage.
// Throughput is one point per cycle.
// A zero depth gives divide_error with zero screen coordinates.
// csr writes take effect at once and belong to idle periods only.
// Reset loads the default registers and empties the pipeline.
module perspective_point_to_screen #(
   parameter int FRAC_BITS   = ppts_pkg::FRAC_BITS_DEF,
   parameter int COORD_WIDTH = ppts_pkg::COORD_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [COORD_WIDTH-1:0]     req_point_x,
   input  logic signed [COORD_WIDTH-1:0]     req_point_y,
   input  logic signed [COORD_WIDTH-1:0]     req_point_z,
   output logic                              rsp_valid,
   output logic signed [COORD_WIDTH-1:0]     rsp_screen_x,
   output logic signed [COORD_WIDTH-1:0]     rsp_screen_y,
   output logic                              rsp_divide_error,
   input  logic                              csr_we,
   input  logic [ppts_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [COORD_WIDTH-1:0]            csr_wdata
);

   localparam int NW  = 2 * COORD_WIDTH + 3;
   localparam int PW  = NW + ppts_pkg::VIEW_BITS + 1;
   localparam int LAT = COORD_WIDTH + 6;
   localparam logic signed [COORD_WIDTH-1:0] ONE_Q = COORD_WIDTH'(1) << FRAC_BITS;

   logic signed [COORD_WIDTH-1:0]     x_scale_ff, x_offset_ff, y_scale_ff, y_offset_ff;
   logic [ppts_pkg::VIEW_BITS-1:0]    view_width_ff, view_height_ff;

   logic signed [COORD_WIDTH:0]       x_lin, x_zc, y_lin, y_zc;
   logic [PW-1:0]                     x_prod, y_prod;
   logic [COORD_WIDTH:0]              x_div, y_div;
   logic                              x_neg, y_neg;
   logic [COORD_WIDTH-1:0]            x_res, y_res;

   logic [LAT-1:0]                    vld_ff, vld_in;
   logic [LAT-1:0]                    zero_ff;
   logic                              accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_scale_ff     <= ONE_Q;
         x_offset_ff    <= '0;
         y_scale_ff     <= -ONE_Q;
         y_offset_ff    <= '0;
         view_width_ff  <= ppts_pkg::VIEW_WIDTH_RST;
         view_height_ff <= ppts_pkg::VIEW_HEIGHT_RST;
      end else if (csr_we) begin
         unique case (ppts_pkg::csr_idx_type'(csr_index))
            ppts_pkg::REG_X_SCALE:     x_scale_ff     <= csr_wdata;
            ppts_pkg::REG_X_OFFSET:    x_offset_ff    <= csr_wdata;
            ppts_pkg::REG_Y_SCALE:     y_scale_ff     <= csr_wdata;
            ppts_pkg::REG_Y_OFFSET:    y_offset_ff    <= csr_wdata;
            ppts_pkg::REG_VIEW_WIDTH:  view_width_ff  <= csr_wdata[ppts_pkg::VIEW_BITS-1:0];
            ppts_pkg::REG_VIEW_HEIGHT: view_height_ff <= csr_wdata[ppts_pkg::VIEW_BITS-1:0];
            default: ;
         endcase
      end
   end

   // x: scale*x + (1 - x_offset)*z, y: -scale*y + (1 + y_offset)*z
   always_comb begin
      x_lin = {x_scale_ff[COORD_WIDTH-1], x_scale_ff};
      x_zc  = {ONE_Q[COORD_WIDTH-1], ONE_Q} - {x_offset_ff[COORD_WIDTH-1], x_offset_ff};
      y_lin = -{y_scale_ff[COORD_WIDTH-1], y_scale_ff};
      y_zc  = {ONE_Q[COORD_WIDTH-1], ONE_Q} + {y_offset_ff[COORD_WIDTH-1], y_offset_ff};
   end

   ppts_axis_front #(.COORD_WIDTH(COORD_WIDTH), .NW(NW), .PW(PW)) u_front_x (
      .clock   (clock),
      .lin     (x_lin),
      .coord   (req_point_x),
      .zc      (x_zc),
      .z       (req_point_z),
      .span    (view_width_ff),
      .prod    (x_prod),
      .divisor (x_div),
      .neg     (x_neg)
   );

   ppts_axis_front #(.COORD_WIDTH(COORD_WIDTH), .NW(NW), .PW(PW)) u_front_y (
      .clock   (clock),
      .lin     (y_lin),
      .coord   (req_point_y),
      .zc      (y_zc),
      .z       (req_point_z),
      .span    (view_height_ff),
      .prod    (y_prod),
      .divisor (y_div),
      .neg     (y_neg)
   );

   ppts_axis_div #(.COORD_WIDTH(COORD_WIDTH), .PW(PW)) u_div_x (
      .clock   (clock),
      .prod    (x_prod),
      .divisor (x_div),
      .neg     (x_neg),
      .result  (x_res)
   );

   ppts_axis_div #(.COORD_WIDTH(COORD_WIDTH), .PW(PW)) u_div_y (
      .clock   (clock),
      .prod    (y_prod),
      .divisor (y_div),
      .neg     (y_neg),
      .result  (y_res)
   );

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   always_comb begin
      vld_in = {vld_ff[LAT-2:0], accept};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      zero_ff <= {zero_ff[LAT-2:0], (req_point_z == '0)};
   end

   assign rsp_valid        = vld_ff[LAT-1];
   assign rsp_divide_error = zero_ff[LAT-1];
   assign rsp_screen_x     = zero_ff[LAT-1] ? '0 : x_res;
   assign rsp_screen_y     = zero_ff[LAT-1] ? '0 : y_res;

endmodule
